>>> design/rbd_pkg.sv
// shared types and constants for the rgba8 2x2 box downsampler
`timescale 1ns / 1ps

package rbd_pkg;

   localparam int CH_W          = 8;     // one color channel
   localparam int SUM_W         = 9;     // sum of two channels
   localparam int LANES         = 4;     // red, green, blue, alpha
   localparam int LINE_W        = LANES * SUM_W;
   localparam int REG_W         = 13;    // size register width
   localparam int ROW_W         = 12;    // row counter width
   localparam int MAX_HEIGHT    = 4096;
   localparam int DEF_MAX_WIDTH = 4096;

   typedef enum logic [0:0] {
      CSR_SRC_WIDTH  = 1'b0,
      CSR_SRC_HEIGHT = 1'b1
   } csr_index_type;

   // per-request controls for the channel lanes
   typedef struct packed {
      logic load;        // request accepted this cycle
      logic one_column;  // pixel stands for both columns of its pair
      logic store_left;  // left pixel of a pair
      logic emit;        // block completes with this request
   } lane_ctrl_type;

   // stage between request accept and the output register
   typedef struct packed {
      logic valid;
      logic last;
      logic same_rows;   // upper row is the pair itself
   } stage_type;

endpackage

>>> design/rgba8_box_downsample_2x2.sv
// top level of the rgba8 2x2 box downsampler
`timescale 1ns / 1ps

// Reduces an RGBA8 raster stream to the next mip level, max(W/2,1) by max(H/2,1),
// each channel the rounded mean (sum+2)>>2 of a 2x2 block; an odd trailing
// column or row is dropped and a dimension of one reuses its samples. One
// source pixel is taken per clock unless a full stage waits on a stalled output;
// the request that completes a block fills the stage register, which moves into
// the output register once that is free. Four channel lanes form horizontal pair
// sums, and a line store of MAX_WIDTH/2 pair sums (one write and one registered
// read per cycle) holds the upper row of each block. The line store needs no
// clearing after reset. Writing src_width or src_height restarts the image.

module rgba8_box_downsample_2x2
   import rbd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [LANES*CH_W-1:0]    req_tdata,   // in_red, in_green, in_blue, in_alpha
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [LANES*CH_W-1:0]    rsp_tdata,   // out_red, out_green, out_blue, out_alpha
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_index,
   input  logic [REG_W-1:0]         csr_data
);

   localparam int Depth = MAX_WIDTH / 2;
   localparam int SlotW = (Depth > 1) ? $clog2(Depth) : 1;

   lane_ctrl_type              lane_ctrl;
   stage_type                  stage;
   logic                       req_accept, stage_go, out_free;
   logic                       line_wr_en, line_rd_en;
   logic [SlotW-1:0]           line_slot;
   logic [LINE_W-1:0]          line_wr_data, line_rd_data;
   logic [LANES-1:0][CH_W-1:0] means;

   assign out_free   = ~rsp_tvalid | rsp_tready;
   assign stage_go   = stage.valid & out_free;
   assign req_tready = ~stage.valid | out_free;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   rbd_ctrl #(
      .MaxWidth (MAX_WIDTH),
      .SlotW    (SlotW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index_type'(csr_index)),
      .csr_data   (csr_data),
      .req_accept (req_accept),
      .stage_go   (stage_go),
      .lane_ctrl  (lane_ctrl),
      .line_wr_en (line_wr_en),
      .line_rd_en (line_rd_en),
      .line_slot  (line_slot),
      .stage      (stage)
   );

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      rbd_lane u_lane (
         .clock     (clock),
         .lane_ctrl (lane_ctrl),
         .pixel     (req_tdata[k*CH_W +: CH_W]),
         .upper_sum (line_rd_data[k*SUM_W +: SUM_W]),
         .same_rows (stage.same_rows),
         .pair_sum  (line_wr_data[k*SUM_W +: SUM_W]),
         .mean      (means[k])
      );
   end

   rbd_line #(
      .Depth (Depth),
      .SlotW (SlotW)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .rd_en   (line_rd_en),
      .slot    (line_slot),
      .wr_data (line_wr_data),
      .rd_data (line_rd_data)
   );

   rbd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .stage_go   (stage_go),
      .stage_last (stage.last),
      .means      (means),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/rbd_ctrl.sv
// position counters, size registers and line store control
`timescale 1ns / 1ps

module rbd_ctrl
   import rbd_pkg::*;
#(
   parameter int MaxWidth = DEF_MAX_WIDTH,
   parameter int SlotW    = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  csr_index_type        csr_index,
   input  logic [REG_W-1:0]     csr_data,
   input  logic                 req_accept,
   input  logic                 stage_go,
   output lane_ctrl_type        lane_ctrl,
   output logic                 line_wr_en,
   output logic                 line_rd_en,
   output logic [SlotW-1:0]     line_slot,
   output stage_type            stage
);

   localparam int ColW = $clog2(MaxWidth);
   localparam int EffW = ($clog2(MaxWidth + 1) > REG_W) ? $clog2(MaxWidth + 1) : REG_W;

   logic [EffW-1:0]  width_ff, width_in;
   logic [REG_W-1:0] height_ff, height_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   stage_type        stage_ff, stage_in;

   logic [EffW-1:0]  wval;
   logic [REG_W-1:0] hval;
   logic             one_col, one_row;
   logic             col_last, row_last;
   logic             pair_done, emit;
   logic [EffW-1:0]  ox, outw_m1;
   logic [REG_W-1:0] oy, outh_m1;

   assign wval = EffW'(csr_data);
   assign hval = csr_data;

   assign one_col  = (width_ff == EffW'(1));
   assign one_row  = (height_ff == REG_W'(1));
   assign col_last = (EffW'(col_ff) == width_ff - EffW'(1));
   assign row_last = (REG_W'(row_ff) == height_ff - REG_W'(1));

   assign pair_done = one_col | col_ff[0];
   assign emit      = pair_done & (one_row | row_ff[0]);

   // output block coordinates and the last block of the reduced image
   assign ox      = one_col ? '0 : EffW'(col_ff >> 1);
   assign outw_m1 = one_col ? '0 : (width_ff >> 1) - EffW'(1);
   assign oy      = one_row ? '0 : REG_W'(row_ff >> 1);
   assign outh_m1 = one_row ? '0 : (height_ff >> 1) - REG_W'(1);

   assign lane_ctrl.load       = req_accept;
   assign lane_ctrl.one_column = one_col;
   assign lane_ctrl.store_left = ~col_ff[0];
   assign lane_ctrl.emit       = emit;

   assign line_wr_en = req_accept & pair_done & ~one_row & ~row_ff[0];
   assign line_rd_en = req_accept & pair_done & ~one_row & row_ff[0];
   assign line_slot  = SlotW'(col_ff >> 1);

   assign stage = stage_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      stage_in  = stage_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_WIDTH: begin
               if (wval == '0) begin
                  width_in = EffW'(1);
               end else if (wval > EffW'(MaxWidth)) begin
                  width_in = EffW'(MaxWidth);
               end else begin
                  width_in = wval;
               end
            end
            CSR_SRC_HEIGHT: begin
               if (hval == '0) begin
                  height_in = REG_W'(1);
               end else if (hval > REG_W'(MAX_HEIGHT)) begin
                  height_in = REG_W'(MAX_HEIGHT);
               end else begin
                  height_in = hval;
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
      if (req_accept && emit) begin
         stage_in.valid     = 1'b1;
         stage_in.last      = (ox == outw_m1) && (oy == outh_m1);
         stage_in.same_rows = one_row;
      end else if (stage_go) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= EffW'(1);
         height_ff <= REG_W'(1);
         col_ff    <= '0;
         row_ff    <= '0;
         stage_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         stage_ff  <= stage_in;
      end
   end

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      EffW'(col_ff) < width_ff)
      else $error("column counter beyond source width");

   a_row_in_range : assert property (@(posedge clock) disable iff (reset)
      REG_W'(row_ff) < height_ff)
      else $error("row counter beyond source height");

   a_stage_from_request : assert property (@(posedge clock) disable iff (reset)
      $rose(stage_ff.valid) |-> $past(req_accept))
      else $error("stage filled without a request");

endmodule

>>> design/rbd_lane.sv
// one color channel: horizontal pair sum and rounded block mean
`timescale 1ns / 1ps

module rbd_lane
   import rbd_pkg::*;
(
   input  logic                clock,
   input  lane_ctrl_type       lane_ctrl,
   input  logic [CH_W-1:0]     pixel,
   input  logic [SUM_W-1:0]    upper_sum,
   input  logic                same_rows,
   output logic [SUM_W-1:0]    pair_sum,
   output logic [CH_W-1:0]     mean
);

   logic [CH_W-1:0]  left_ff;
   logic [SUM_W-1:0] pair_ff;
   logic [SUM_W-1:0] upper;
   logic [SUM_W:0]   total;

   assign pair_sum = lane_ctrl.one_column
                     ? SUM_W'(pixel) + SUM_W'(pixel)
                     : SUM_W'(left_ff) + SUM_W'(pixel);

   // round to nearest: (sum + 2) >> 2
   assign upper = same_rows ? pair_ff : upper_sum;
   assign total = (SUM_W + 1)'(upper) + (SUM_W + 1)'(pair_ff) + (SUM_W + 1)'(2);
   assign mean  = total[SUM_W:2];

   always_ff @(posedge clock) begin
      if (lane_ctrl.load && lane_ctrl.store_left) begin
         left_ff <= pixel;
      end
      if (lane_ctrl.load && lane_ctrl.emit) begin
         pair_ff <= pair_sum;
      end
   end

endmodule

>>> design/rbd_line.sv
// line store of upper-row pair sums, one write and one registered read port
`timescale 1ns / 1ps

module rbd_line
   import rbd_pkg::*;
#(
   parameter int Depth = DEF_MAX_WIDTH / 2,
   parameter int SlotW = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic               rd_en,
   input  logic [SlotW-1:0]   slot,
   input  logic [LINE_W-1:0]  wr_data,
   output logic [LINE_W-1:0]  rd_data
);

   logic [LINE_W-1:0] mem [Depth];
   logic [LINE_W-1:0] rd_ff;

   assign rd_data = rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[slot];
      end
   end

endmodule

>>> design/rbd_merge.sv
// gathers the lane means into the output register
`timescale 1ns / 1ps

module rbd_merge
   import rbd_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             stage_go,
   input  logic                             stage_last,
   input  logic [LANES-1:0][CH_W-1:0]       means,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [LANES*CH_W-1:0]            rsp_tdata,
   output logic                             rsp_tlast
);

   logic                    valid_ff, valid_in;
   logic [LANES*CH_W-1:0]   data_ff;
   logic                    last_ff;

   assign valid_in   = stage_go | (valid_ff & ~rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_go) begin
         data_ff <= means;
         last_ff <= stage_last;
      end
   end

endmodule
